// File: hdl/bctd_pkg.sv
// ----------------------------------------------------------------------------
// bctd_pkg
// Shared types and constants of the block cache tag directory.
// ----------------------------------------------------------------------------
package bctd_pkg;

  localparam int LOC_W          = 48;
  localparam int LEFT_W         = 32;
  localparam int SLOT_W         = 9;
  localparam int OFF_W          = 14;
  localparam int CHUNK_W        = 15;
  localparam int TAG_W          = 40;
  localparam int LG_W           = 4;

  localparam logic [LG_W-1:0] LG_MIN   = 4'd9;
  localparam logic [LG_W-1:0] LG_MAX   = 4'd12;
  localparam logic [LG_W-1:0] LG_RESET = 4'd9;

  localparam int ENTRIES_DEF    = 512;
  localparam int LBAS_PER_BLOCK = 4;
  localparam int LBAS_LOG2      = $clog2(LBAS_PER_BLOCK);

  typedef struct packed {
    logic [LOC_W-1:0]  byte_location;
    logic [LEFT_W-1:0] bytes_left;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [OFF_W-1:0]   block_offset;
    logic [CHUNK_W-1:0] chunk_bytes;
    logic [LOC_W-1:0]   fill_lba;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

endpackage

// File: hdl/bctd_if.sv
// ----------------------------------------------------------------------------
// bctd_if
// Valid/ready channels of the tag directory: request and response.
// ----------------------------------------------------------------------------
interface bctd_req_if;
  import bctd_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bctd_rsp_if;
  import bctd_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/bctd_ram.sv
// ----------------------------------------------------------------------------
// bctd_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bctd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: hdl/block_cache_tag_directory.sv
// ----------------------------------------------------------------------------
// block_cache_tag_directory
// Tag directory of a fully associative block cache with round-robin reuse.
//
// Request channel req_i carries byte_location and bytes_left; one response
// on rsp_o per request: hit, slot, block_offset, chunk_bytes, fill_lba.
// cfg_we_i/cfg_wdata_i write lba_size_log2 (clamped to 9..12 on use).
// One request is in work at a time. Entries fill from slot 0 upward and are
// never dropped, so a fill count stands in for per-entry valid bits.
// A lookup reads the tag RAM one entry per cycle over the filled entries
// and stops at the first hit or after the last filled entry; req_i is
// ready again in the cycle the response appears.
// The tag RAM read port sets the length of a lookup.
// The response sits in an output register; while rsp_o stalls, the block
// may take and search the next request, then waits to load its result.
// Reset empties the directory (fill count and pointer to zero) at once and
// sets lba_size_log2 to 9; no clearing pass is needed.
// ----------------------------------------------------------------------------
module block_cache_tag_directory
  import bctd_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bctd_pkg::LG_W-1:0]  cfg_wdata_i,
  bctd_req_if.sink                   req_i,
  bctd_rsp_if.source                 rsp_o
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  state_e state_q, state_d;

  logic [LG_W-1:0]    lg_q;
  logic [CNT_W-1:0]   count_q;
  logic [IDX_W-1:0]   rp_q;
  logic [CNT_W-1:0]   addr_q;
  logic               pend_q;
  logic [IDX_W-1:0]   pend_idx_q;

  logic [TAG_W-1:0]   tag_q;
  logic [OFF_W-1:0]   off_q;
  logic [CHUNK_W-1:0] chunk_q;
  logic [LOC_W-1:0]   fill_q;
  logic               hit_q;
  logic [IDX_W-1:0]   slot_q;

  logic               out_valid_q;
  rsp_t               out_q;

  // request decode
  logic [LG_W-1:0]    lg_c;
  logic [LG_W-1:0]    sh;
  logic [LOC_W-1:0]   blk;
  logic [LOC_W-1:0]   off_mask;
  logic [OFF_W-1:0]   off;
  logic [CHUNK_W-1:0] bsize;
  logic [CHUNK_W-1:0] rest;
  logic [CHUNK_W-1:0] chunk;

  always_comb begin
    lg_c = lg_q;
    if (lg_q < LG_MIN) begin
      lg_c = LG_MIN;
    end else if (lg_q > LG_MAX) begin
      lg_c = LG_MAX;
    end
    sh       = LG_W'(lg_c + LG_W'(LBAS_LOG2));
    blk      = req_i.data.byte_location >> sh;
    off_mask = ~({LOC_W{1'b1}} << sh);
    off      = OFF_W'(req_i.data.byte_location & off_mask);
    bsize    = CHUNK_W'(1) << sh;
    rest     = bsize - CHUNK_W'(off);
    chunk    = (req_i.data.bytes_left < LEFT_W'(rest)) ?
               CHUNK_W'(req_i.data.bytes_left) : rest;
  end

  // tag RAM
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  logic [TAG_W-1:0] ram_rdata;

  bctd_ram #(
    .WIDTH (TAG_W),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (tag_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic match;
  logic scan_end;
  logic full;
  logic out_free;
  logic req_xfer;

  assign match    = pend_q && (ram_rdata == tag_q);
  assign scan_end = (addr_q == count_q);
  assign full     = (count_q == CNT_W'(ENTRIES));
  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_xfer = req_i.valid && req_i.ready;
  assign ram_raddr = addr_q[IDX_W-1:0];
  assign ram_waddr = full ? rp_q : count_q[IDX_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (match || scan_end) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  logic issue;
  logic take_hit;
  logic load_out;

  always_comb begin
    req_i.ready = 1'b0;
    issue       = 1'b0;
    take_hit    = 1'b0;
    ram_we      = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      ST_IDLE: req_i.ready = 1'b1;
      ST_SCAN: begin
        if (match) begin
          take_hit = 1'b1;
        end else if (scan_end) begin
          ram_we = 1'b1;
        end else begin
          issue = 1'b1;
        end
      end
      ST_RESP: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lg_q        <= LG_RESET;
      count_q     <= '0;
      rp_q        <= '0;
      addr_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        lg_q <= cfg_wdata_i;
      end
      if (req_xfer) begin
        addr_q <= '0;
        pend_q <= 1'b0;
      end else if (issue) begin
        addr_q <= addr_q + CNT_W'(1);
        pend_q <= 1'b1;
      end else begin
        pend_q <= 1'b0;
      end
      if (ram_we) begin
        if (full) begin
          rp_q <= (rp_q == IDX_W'(ENTRIES - 1)) ? '0 : rp_q + IDX_W'(1);
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      tag_q   <= TAG_W'(blk);
      off_q   <= off;
      chunk_q <= chunk;
      fill_q  <= LOC_W'(blk << LBAS_LOG2);
    end
    if (issue) begin
      pend_idx_q <= addr_q[IDX_W-1:0];
    end
    if (take_hit) begin
      hit_q  <= 1'b1;
      slot_q <= pend_idx_q;
    end else if (ram_we) begin
      hit_q  <= 1'b0;
      slot_q <= ram_waddr;
    end
    if (load_out) begin
      out_q.hit          <= hit_q;
      out_q.slot         <= SLOT_W'(slot_q);
      out_q.block_offset <= off_q;
      out_q.chunk_bytes  <= chunk_q;
      out_q.fill_lba     <= hit_q ? '0 : fill_q;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

// File: hdl/bctd_checker.sv
// ----------------------------------------------------------------------------
// bctd_port_checker
// Port-level checks of the tag directory, bound to the top level.
// ----------------------------------------------------------------------------
module bctd_port_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_ready_i,
  input  logic          rsp_valid_i,
  input  logic          rsp_ready_i,
  input  bctd_pkg::rsp_t rsp_data_i
);
  import bctd_pkg::*;

  localparam logic [CHUNK_W:0] MAX_BLOCK = (CHUNK_W+1)'(LBAS_PER_BLOCK) << LG_MAX;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_data_i))
    else $error("response changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous lookup in work");

  a_hit_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.hit |-> rsp_data_i.fill_lba == '0)
    else $error("fill requested on a hit");

  a_chunk_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> ((CHUNK_W+1)'(rsp_data_i.block_offset)
                     + (CHUNK_W+1)'(rsp_data_i.chunk_bytes)) <= MAX_BLOCK)
    else $error("transfer crosses cache block end");

endmodule

bind block_cache_tag_directory bctd_port_checker u_bctd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

// File: tb/bctd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctd_checker
// Scoreboard of the tag directory. Tracks the block size register and keeps
// its own tag store, valid bits and round-robin pointer. Every request
// transfer yields a predicted response. Every response transfer is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bctd_checker
  import bctd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LG_W-1:0]  cfg_wdata_i,
  bctd_req_if              req_i,
  bctd_rsp_if              rsp_i,
  output int               errors_o,
  output int               pending_o,
  output int               lookups_o,
  output int               hits_o,
  output int               replacements_o
);

  localparam int ENTRIES = ENTRIES_DEF;

  logic [TAG_W-1:0] tag_mem [ENTRIES];
  bit               tag_valid [ENTRIES];
  int unsigned      victim_ptr;
  logic [LG_W-1:0]  size_lg;
  rsp_t             rsp_due_q [$];

  function automatic rsp_t lookup_directory(input logic [LOC_W-1:0] loc,
                                            input logic [LEFT_W-1:0] left);
    int unsigned      lg;
    logic [63:0]      bsize;
    logic [63:0]      blk;
    logic [63:0]      off;
    logic [63:0]      rest;
    logic [63:0]      chunk;
    logic [TAG_W-1:0] tag;
    int               target;
    bit               hit;
    bit               found;
    rsp_t             r;
    lg = (size_lg < LG_MIN) ? LG_MIN : ((size_lg > LG_MAX) ? LG_MAX : size_lg);
    bsize = 64'(LBAS_PER_BLOCK) << lg;
    blk = 64'(loc) / bsize;
    off = 64'(loc) % bsize;
    tag = blk[TAG_W-1:0];
    target = 0;
    hit = 1'b0;
    found = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tag_valid[i] && tag_mem[i] == tag) begin
        target = i;
        hit = 1'b1;
        break;
      end
    end
    if (!hit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!tag_valid[i]) begin
          target = i;
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        target = victim_ptr;
        victim_ptr = (victim_ptr + 1) % ENTRIES;
        replacements_o++;
      end
      tag_mem[target] = tag;
      tag_valid[target] = 1'b1;
    end else begin
      hits_o++;
    end
    rest = bsize - off;
    chunk = (64'(left) < rest) ? 64'(left) : rest;
    r.hit = hit;
    r.slot = SLOT_W'(target);
    r.block_offset = off[OFF_W-1:0];
    r.chunk_bytes = chunk[CHUNK_W-1:0];
    r.fill_lba = hit ? '0 : LOC_W'(blk * LBAS_PER_BLOCK);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] bctd_checker: MISMATCH %s", $time, msg);
    errors_o++;
  endtask

  task automatic check_response(input rsp_t got);
    rsp_t want;
    if (rsp_due_q.size() == 0) begin
      report_mismatch($sformatf("response with no request outstanding (slot %0d)", got.slot));
    end else begin
      want = rsp_due_q.pop_front();
      if (got.hit !== want.hit)
        report_mismatch($sformatf("hit: expected %0d got %0d", want.hit, got.hit));
      if (got.slot !== want.slot)
        report_mismatch($sformatf("slot: expected %0d got %0d", want.slot, got.slot));
      if (got.block_offset !== want.block_offset)
        report_mismatch($sformatf("block_offset: expected %0d got %0d",
                                  want.block_offset, got.block_offset));
      if (got.chunk_bytes !== want.chunk_bytes)
        report_mismatch($sformatf("chunk_bytes: expected %0d got %0d",
                                  want.chunk_bytes, got.chunk_bytes));
      if (got.fill_lba !== want.fill_lba)
        report_mismatch($sformatf("fill_lba: expected %h got %h",
                                  want.fill_lba, got.fill_lba));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tag_valid[i] = 1'b0;
        tag_mem[i] = '0;
      end
      victim_ptr = 0;
      size_lg = LG_RESET;
      rsp_due_q.delete();
      errors_o = 0;
      pending_o = 0;
      lookups_o = 0;
      hits_o = 0;
      replacements_o = 0;
    end else begin
      if (cfg_we_i) size_lg = cfg_wdata_i;
      if (rsp_i.valid && rsp_i.ready) check_response(rsp_i.data);
      if (req_i.valid && req_i.ready) begin
        rsp_due_q.push_back(lookup_directory(req_i.data.byte_location,
                                             req_i.data.bytes_left));
        lookups_o++;
      end
      pending_o = rsp_due_q.size();
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the block cache tag directory. A directed part covers the
// address and length extremes, zero-length transfers, clamped block sizes and
// size changes with live entries. A random part then fills the directory,
// drives it through round-robin replacement across several block sizes, and
// mixes in repeat hits. Bursty requests, patterned response stalls and one
// long response hold-off exercise the handshakes.
// ----------------------------------------------------------------------------
module tb;
  import bctd_pkg::*;

  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 144;
  localparam int HOLD_START    = 30000;
  localparam int HOLD_CYCLES   = 3000;
  localparam int DRAIN_CYCLES  = 600;
  localparam int WATCHDOG_MAX  = 20000;

  typedef enum int {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_RARELY,
    RDY_PATTERN,
    RDY_HOLD
  } ready_mode_e;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we;
  logic [LG_W-1:0] cfg_wdata;

  int          errors;
  int          pending;
  int          lookups;
  int          hits;
  int          replacements;
  int          burst_left;
  int          cfg_writes;
  int          idle_cycles;
  int unsigned cur_bsize;

  bctd_req_if req_if ();
  bctd_rsp_if rsp_if ();

  block_cache_tag_directory u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  bctd_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .req_i          (req_if),
    .rsp_i          (rsp_if),
    .errors_o       (errors),
    .pending_o      (pending),
    .lookups_o      (lookups),
    .hits_o         (hits),
    .replacements_o (replacements)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, idle_cycles);
        $display("** block_cache_tag_directory: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  task automatic offer_request(input logic [LOC_W-1:0] loc, input logic [LEFT_W-1:0] left);
    int gap;
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 600) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
    end
    req_if.valid <= 1'b1;
    req_if.data <= '{byte_location: loc, bytes_left: left};
    do @(posedge clk_i); while (!req_if.ready);
    burst_left--;
  endtask

  // Register writes happen only with the directory drained.
  task automatic set_block_size(input logic [LG_W-1:0] lg);
    int unsigned eff;
    req_if.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= lg;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    eff = (lg < LG_MIN) ? LG_MIN : ((lg > LG_MAX) ? LG_MAX : lg);
    cur_bsize = LBAS_PER_BLOCK << eff;
    cfg_writes++;
  endtask

  // Response side: stall patterns, plus one long hold-off to back up the input.
  initial begin
    ready_mode_e mode;
    int          span;
    int          cycles;
    bit          held;
    rsp_if.ready <= 1'b0;
    cycles = 0;
    held = 1'b0;
    forever begin
      mode = ready_mode_e'($urandom_range(0, 4));
      span = $urandom_range(20, 400);
      if (!held && cycles >= HOLD_START) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk_i);
          rsp_if.ready <= 1'b0;
        end
        cycles += HOLD_CYCLES;
      end
      for (int k = 0; k < span; k++) begin
        @(posedge clk_i);
        cycles++;
        case (mode)
          RDY_ALWAYS:  rsp_if.ready <= 1'b1;
          RDY_MOSTLY:  rsp_if.ready <= ($urandom_range(0, 3) != 0);
          RDY_RARELY:  rsp_if.ready <= ($urandom_range(0, 3) == 0);
          RDY_PATTERN: rsp_if.ready <= (k % 3 != 0);
          default:     rsp_if.ready <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    logic [LG_W-1:0]   phase_lg [PHASES];
    logic [LOC_W-1:0]  recent [$];
    logic [LOC_W-1:0]  loc;
    logic [LOC_W-1:0]  base;
    logic [LOC_W-1:0]  last_loc;
    logic [LEFT_W-1:0] left;
    int                pick;

    phase_lg = '{4'd9, 4'd12, 4'd10, 4'd11, 4'd14, 4'd9, 4'd1, 4'd12};
    burst_left = 0;
    cfg_writes = 0;
    cur_bsize = LBAS_PER_BLOCK << LG_RESET;
    last_loc = '0;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_if.valid <= 1'b0;
    req_if.data <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset block size: 2 KiB cache blocks
    offer_request(48'd0, 32'd0);
    offer_request(48'd0, 32'd1);
    offer_request(48'd2047, '1);
    offer_request(48'd2048, 32'd2048);
    offer_request('1, '1);
    offer_request('1, 32'd0);
    offer_request(48'd1000, 32'd5000);
    // below range, used as the minimum
    set_block_size(4'd0);
    offer_request(48'd4096, 32'd100);
    // above range, used as the maximum; old entries compared as new block numbers
    set_block_size(4'd15);
    offer_request(48'd0, 32'd16384);
    offer_request(48'd16383, 32'd16384);
    offer_request(48'd20000, 32'd1);
    offer_request('1, 32'd40000);
    set_block_size(4'd12);
    offer_request(48'd114693, 32'd16379);
    set_block_size(4'd10);
    offer_request(48'd12288, 32'd4096);
    offer_request(48'd12291, 32'd0);
    set_block_size(4'd11);
    offer_request(48'd49151, 32'd2);

    for (int p = 0; p < PHASES; p++) begin
      set_block_size(phase_lg[p]);
      recent.delete();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 7 && recent.size() > 0) begin
          base = recent[$urandom_range(0, recent.size() - 1)];
          loc = base - (base % cur_bsize) + LOC_W'($urandom_range(0, cur_bsize - 1));
        end else if (pick < 15) begin
          loc = last_loc + cur_bsize;
        end else if (pick < 20) begin
          loc = LOC_W'($urandom_range(0, 32'h000F_FFFF));
        end else begin
          loc = LOC_W'({$urandom, $urandom});
        end
        recent.push_back(loc);
        if (recent.size() > 64) void'(recent.pop_front());
        last_loc = loc;
        pick = $urandom_range(0, 19);
        if (pick == 0) left = '0;
        else if (pick == 1) left = '1;
        else if (pick < 7) left = $urandom;
        else if (pick < 13) left = $urandom_range(1, 2 * cur_bsize);
        else left = $urandom_range(1, cur_bsize);
        offer_request(loc, left);
      end
    end

    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d lookups: %0d hits, %0d misses, %0d round-robin replacements",
             lookups, hits, lookups - hits, replacements);
    $display("Block size register written %0d times, clamped values included", cfg_writes);
    if (errors == 0 && pending == 0) begin
      $display("** block_cache_tag_directory: PASSED **");
    end else begin
      $display("** block_cache_tag_directory: FAILED **");
    end
    $finish;
  end

endmodule
